>>> src/umo_pkg.sv
// Package for the unsmoothed momentum oscillator: widths, constants, FSM state,
// divider request/response types and the window length clamp.
// No dependencies.
package umo_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W      = 7;
  localparam int CHG_W      = PRICE_BITS + 1;
  localparam int TOTAL_BITS = PRICE_BITS + 12;
  localparam int SUM_W      = TOTAL_BITS + 1;
  localparam int REM_W      = TOTAL_BITS + 2;
  localparam int OSC_W      = 16;
  localparam int IDX_W      = 32;
  localparam int DIV_STEPS  = 2 * OSC_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0]      LEN_RESET = CFG_W'(14);
  localparam logic [OSC_W-1:0]      SCALE     = OSC_W'(25600);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      IDX_MAX   = {IDX_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_ADD,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [TOTAL_BITS-1:0] num;
    logic [SUM_W-1:0]      den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OSC_W-1:0] quot;
  } div_rsp_t;

  // 0 acts as 1, anything above the ring depth acts as the ring depth
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] w);
    if (w == '0) begin
      return LEN_W'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      return LEN_W'(MAX_WINDOW);
    end else begin
      return LEN_W'(w);
    end
  endfunction

endpackage

>>> src/umo_ifs.sv
// Stream and configuration interfaces of the momentum oscillator.
// Depends on umo_pkg.
interface umo_sample_if;
  import umo_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [PRICE_BITS-1:0] price;
  logic                         first_sample;
  logic                         last_sample;
  modport source (output valid, price, first_sample, last_sample, input ready);
  modport sink   (input valid, price, first_sample, last_sample, output ready);
endinterface

interface umo_result_if;
  import umo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OSC_W-1:0] oscillator;
  logic [IDX_W-1:0]        sample_index;
  logic                    last_result;
  modport source (output valid, oscillator, sample_index, last_result, input ready);
  modport sink   (input valid, oscillator, sample_index, last_result, output ready);
endinterface

interface umo_cfg_if;
  import umo_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_length;
  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

>>> src/umo_div.sv
// Iterative scaled-ratio unit: floor(num * SCALE / den) for num <= den, den > 0.
// Two half-steps per quotient bit, one compare-subtract each. Depends on umo_pkg.
module umo_div (
  input  logic              clk,
  input  logic              rst,
  input  umo_pkg::div_req_t req,
  output umo_pkg::div_rsp_t rsp
);
  import umo_pkg::*;

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [REM_W-1:0]      rem;
  logic [OSC_W-1:0]      quot;
  logic [TOTAL_BITS-1:0] num;
  logic [SUM_W-1:0]      den;
  logic                  done;

  logic [REM_W-1:0] rem_try;
  logic             take;
  logic [3:0]       bit_sel;
  logic             add_phase;

  assign add_phase = step[0];
  assign bit_sel   = ~step[STEP_W-1:1];

  always_comb begin
    if (!add_phase) begin
      rem_try = {rem[REM_W-2:0], 1'b0};
    end else if (SCALE[bit_sel]) begin
      rem_try = rem + REM_W'(num);
    end else begin
      rem_try = rem;
    end
    take = (rem_try >= REM_W'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_W'(DIV_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= '0;
      num  <= req.num;
      den  <= req.den;
    end else if (busy) begin
      rem <= take ? rem_try - REM_W'(den) : rem_try;
      if (!add_phase) begin
        quot <= {quot[OSC_W-2:0], 1'b0} + OSC_W'(take);
      end else begin
        quot <= quot + OSC_W'(take);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> src/unsmoothed_momentum_oscillator_unit.sv
// Top level of the unsmoothed momentum oscillator.
// Depends on umo_pkg, umo_ifs (stream and config interfaces) and umo_div.
//
// Usage:
//   samples  - input stream, one beat per price sample (price, first_sample,
//              last_sample). A beat moves when valid and ready are both high.
//   results  - output stream, at most one beat per sample: oscillator
//              (256 * CMO, -25600..25600, truncated toward zero), sample_index
//              and last_result.
//   cfg      - write channel for window_length; always ready. Write it only
//              while no sample is in flight.
// Flow: samples are processed one at a time. A warm-up sample frees the
//   input after the drop and add steps, back in idle; a sample that yields a
//   result goes on through sum, the half-steps of the iterative ratio unit
//   and emit. A flat window skips the divider and goes from sum to emit.
// The change ring is one memory with a registered read: read at acceptance,
//   written back in the drop cycle, so the same entry never overlaps.
// Reset: synchronous, clears the series state and sets window_length to 14;
//   the ring itself is not cleared and needs no clearing pass.
// Stall: the result sits in an output register; the next sample is accepted
//   and processed while it waits, and only the emit step holds until the
//   register frees up.
module unsmoothed_momentum_oscillator_unit (
  input logic          clk,
  input logic          rst,
  umo_sample_if.sink   samples,
  umo_result_if.source results,
  umo_cfg_if.sink      cfg
);
  import umo_pkg::*;

  function automatic logic [TOTAL_BITS-1:0] sat_sub(input logic [TOTAL_BITS-1:0] a,
                                                    input logic [CHG_W-1:0] b);
    if (TOTAL_BITS'(b) > a) begin
      return '0;
    end
    return a - TOTAL_BITS'(b);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                    input logic [CHG_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + SUM_W'(b);
    if (s > SUM_W'(TOTAL_MAX)) begin
      return TOTAL_MAX;
    end
    return s[TOTAL_BITS-1:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] window_length;
  logic [LEN_W-1:0] len;

  assign cfg.ready = 1'b1;
  assign len       = eff_len(window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg.valid) begin
      window_length <= cfg.window_length;
    end
  end

  // control
  state_t state, state_next;
  logic   accept;
  logic   out_load;

  // series state
  logic signed [PRICE_BITS-1:0] prev_price;
  logic [PTR_W-1:0]             ring_pointer;
  logic [TOTAL_BITS-1:0]        up_total;
  logic [TOTAL_BITS-1:0]        down_total;
  logic [IDX_W-1:0]             samples_seen;
  logic [LEN_W-1:0]             flat_run;

  // per-sample working registers
  logic signed [PRICE_BITS-1:0] price_q;
  logic                         last_q;
  logic [IDX_W-1:0]             idx_q;
  logic [CHG_W-1:0]             change;
  logic                         have_d;
  logic                         drop_q;
  logic                         emit_q;
  logic                         neg_q;
  logic [OSC_W-1:0]             osc_q;

  // output register
  logic             out_valid;
  logic [OSC_W-1:0] out_osc;
  logic [IDX_W-1:0] out_idx;
  logic             out_last;

  // change ring
  logic [CHG_W-1:0] ring [MAX_WINDOW];
  logic [CHG_W-1:0] ring_q;
  logic             ring_we;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // accept-cycle pointer: restart, then wrap if the window shrank
  logic [PTR_W-1:0] ptr_start;
  logic [PTR_W-1:0] ptr_eff;

  // drop-cycle terms
  logic             have_d_c;
  logic             drop_c;
  logic             emit_c;
  logic [CHG_W-1:0] d_c;
  logic [CHG_W-1:0] old_mag;
  logic [PTR_W:0]   ptr_inc;

  // add-cycle terms
  logic [CHG_W-1:0] d_mag;
  logic [LEN_W-1:0] flat_next;
  logic             flat_clear;

  // sum-cycle terms
  logic [SUM_W-1:0]      sum_c;
  logic                  up_ge;
  logic [TOTAL_BITS-1:0] diff_c;

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == ST_IDLE);

  assign ptr_start = samples.first_sample ? '0 : ring_pointer;
  assign ptr_eff   = (LEN_W'(ptr_start) >= len) ? '0 : ptr_start;

  assign have_d_c = (samples_seen != '0);
  assign drop_c   = (samples_seen > IDX_W'(len));
  assign emit_c   = (samples_seen >= IDX_W'(len));
  assign d_c      = {price_q[PRICE_BITS-1], price_q} - {prev_price[PRICE_BITS-1], prev_price};
  assign old_mag  = ring_q[CHG_W-1] ? (CHG_W'(0) - ring_q) : ring_q;
  assign ptr_inc  = {1'b0, ring_pointer} + 1'b1;
  assign ring_we  = (state == ST_DROP) && have_d_c;

  assign d_mag      = change[CHG_W-1] ? (CHG_W'(0) - change) : change;
  assign flat_next  = (change != '0) ? '0 : ((flat_run < len) ? flat_run + 1'b1 : flat_run);
  assign flat_clear = drop_q && (flat_next >= len);

  assign sum_c  = {1'b0, up_total} + {1'b0, down_total};
  assign up_ge  = (up_total >= down_total);
  assign diff_c = up_ge ? up_total - down_total : down_total - up_total;

  assign div_req.start = (state == ST_SUM) && (sum_c != '0);
  assign div_req.num   = diff_c;
  assign div_req.den   = sum_c;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_pointer] <= d_c;
    end
    if (accept) begin
      ring_q <= ring[ptr_eff];
    end
  end

  umo_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DROP;
        end
      end
      ST_DROP: state_next = ST_ADD;
      ST_ADD:  state_next = emit_q ? ST_SUM : ST_IDLE;
      ST_SUM:  state_next = (sum_c != '0) ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // series state: clear on first_sample at acceptance, then drop/add steps
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_price   <= '0;
      ring_pointer <= '0;
      up_total     <= '0;
      down_total   <= '0;
      samples_seen <= '0;
      flat_run     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ring_pointer <= ptr_eff;
            if (samples.first_sample) begin
              prev_price   <= '0;
              up_total     <= '0;
              down_total   <= '0;
              samples_seen <= '0;
              flat_run     <= '0;
            end
          end
        end
        ST_DROP: begin
          if (samples_seen != IDX_MAX) begin
            samples_seen <= samples_seen + 1'b1;
          end
          if (have_d_c) begin
            ring_pointer <= (ptr_inc >= (PTR_W + 1)'(len)) ? '0 : ptr_inc[PTR_W-1:0];
          end
          // retire the oldest change once the window is full
          if (drop_c && ring_q != '0) begin
            if (ring_q[CHG_W-1]) begin
              down_total <= sat_sub(down_total, old_mag);
            end else begin
              up_total <= sat_sub(up_total, old_mag);
            end
          end
        end
        ST_ADD: begin
          prev_price <= price_q;
          if (have_d) begin
            if (flat_clear) begin
              flat_run   <= len;
              up_total   <= '0;
              down_total <= '0;
            end else begin
              flat_run <= flat_next;
              if (change != '0) begin
                if (change[CHG_W-1]) begin
                  down_total <= sat_add(down_total, d_mag);
                end else begin
                  up_total <= sat_add(up_total, d_mag);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-sample payload
  always_ff @(posedge clk) begin
    if (accept) begin
      price_q <= samples.price;
      last_q  <= samples.last_sample;
    end
    if (state == ST_DROP) begin
      idx_q  <= samples_seen;
      change <= d_c;
      have_d <= have_d_c;
      drop_q <= drop_c;
      emit_q <= emit_c;
    end
    if (state == ST_SUM) begin
      neg_q <= !up_ge;
      osc_q <= '0;
    end
    if (state == ST_DIV && div_rsp.done) begin
      osc_q <= neg_q ? (OSC_W'(0) - div_rsp.quot) : div_rsp.quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_osc  <= osc_q;
      out_idx  <= idx_q;
      out_last <= last_q;
    end
  end

  assign results.valid        = out_valid;
  assign results.oscillator   = out_osc;
  assign results.sample_index = out_idx;
  assign results.last_result  = out_last;

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("ratio unit finished outside the divide step");

  a_accept_to_drop: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DROP)
    else $error("accepted sample did not move to the drop step");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!out_valid || results.ready)) |=> out_valid)
    else $error("emit step did not load the output register");

  a_osc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_osc) <= $signed(OSC_W'(25600)) &&
                   $signed(out_osc) >= -$signed(OSC_W'(25600))))
    else $error("oscillator out of range");

endmodule

>>> dv/umo_checker.sv
// Checker for the unsmoothed momentum oscillator: watches the sample, result and
// config channels, predicts each result beat and compares it field by field.
// Depends on umo_pkg and umo_ifs.
module umo_checker (
  input  logic  clk,
  input  logic  rst,
  umo_sample_if samples,
  umo_result_if results,
  umo_cfg_if    cfg,
  output int    errors,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import umo_pkg::*;

  typedef struct packed {
    logic signed [OSC_W-1:0] oscillator;
    logic [IDX_W-1:0]        sample_index;
    logic                    last_result;
  } osc_beat_t;

  osc_beat_t osc_expected[$];

  // shadow of the series state
  logic [CFG_W-1:0]             win_reg;
  logic signed [PRICE_BITS-1:0] last_price;
  logic signed [CHG_W-1:0]      change_hist [MAX_WINDOW];
  int unsigned                  hist_ptr;
  int unsigned                  seen_count;
  int unsigned                  flat_count;
  logic [TOTAL_BITS-1:0]        rise_sum;
  logic [TOTAL_BITS-1:0]        fall_sum;
  int                           mismatches;

  function automatic int unsigned window_span(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (int'(w) > MAX_WINDOW) return MAX_WINDOW;
    return int'(w);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] sum_plus(input logic [TOTAL_BITS-1:0] a,
                                                     input logic [CHG_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_BITS-1:0];
  endfunction

  function automatic logic [TOTAL_BITS-1:0] sum_minus(input logic [TOTAL_BITS-1:0] a,
                                                      input logic [CHG_W-1:0] b);
    return (TOTAL_BITS'(b) > a) ? '0 : a - TOTAL_BITS'(b);
  endfunction

  // floor(n * 25600 / s); the product fits in 64 bits, and n <= s keeps the result within 25600
  function automatic logic [OSC_W-1:0] scaled_share(input logic [TOTAL_BITS-1:0] n,
                                                    input logic [SUM_W-1:0] s);
    logic [63:0] prod;
    prod = 64'(n) * 64'(SCALE);
    return OSC_W'(prod / 64'(s));
  endfunction

  function automatic void clear_series();
    last_price = '0;
    hist_ptr   = 0;
    rise_sum   = '0;
    fall_sum   = '0;
    seen_count = 0;
    flat_count = 0;
  endfunction

  task automatic predict_beat(input logic signed [PRICE_BITS-1:0] price,
                              input logic is_first, input logic is_last);
    int unsigned             span;
    int unsigned             idx;
    logic signed [CHG_W-1:0] delta;
    logic signed [CHG_W-1:0] dropped;
    logic [CHG_W-1:0]        mag;
    logic [SUM_W-1:0]        both;
    logic [OSC_W-1:0]        share;
    osc_beat_t               beat;
    span = window_span(win_reg);
    if (is_first) clear_series();
    if (hist_ptr >= span) hist_ptr = 0;
    idx = seen_count;
    if (seen_count != IDX_MAX) seen_count++;
    if (idx >= 1) begin
      delta = {price[PRICE_BITS-1], price} - {last_price[PRICE_BITS-1], last_price};
      if (idx - 1 >= span) begin
        dropped = change_hist[hist_ptr];
        mag = dropped[CHG_W-1] ? -dropped : dropped;
        if (dropped > 0) rise_sum = sum_minus(rise_sum, mag);
        else if (dropped < 0) fall_sum = sum_minus(fall_sum, mag);
      end
      change_hist[hist_ptr] = delta;
      hist_ptr = (hist_ptr + 1 >= span) ? 0 : hist_ptr + 1;
      mag = delta[CHG_W-1] ? -delta : delta;
      if (delta > 0) rise_sum = sum_plus(rise_sum, mag);
      else if (delta < 0) fall_sum = sum_plus(fall_sum, mag);
      if (delta == 0) begin
        if (flat_count < span) flat_count++;
      end else begin
        flat_count = 0;
      end
      if (idx > span && flat_count >= span) begin
        flat_count = span;
        rise_sum = '0;
        fall_sum = '0;
      end
    end
    last_price = price;
    if (idx >= span) begin
      both  = SUM_W'(rise_sum) + SUM_W'(fall_sum);
      share = '0;
      if (both != '0) begin
        if (rise_sum >= fall_sum) share = scaled_share(rise_sum - fall_sum, both);
        else share = -scaled_share(fall_sum - rise_sum, both);
      end
      beat.oscillator   = share;
      beat.sample_index = idx;
      beat.last_result  = is_last;
      osc_expected.push_back(beat);
    end
  endtask

  always @(posedge clk) begin : watch
    osc_beat_t got;
    osc_beat_t want;
    if (rst) begin
      win_reg = LEN_RESET;
      clear_series();
      osc_expected.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) win_reg = cfg.window_length;
      // result check first: a beat leaving now belongs to an older sample
      if (results.valid && results.ready) begin
        got.oscillator   = results.oscillator;
        got.sample_index = results.sample_index;
        got.last_result  = results.last_result;
        if (osc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: osc %0d index %0d last %0b",
                     got.oscillator, got.sample_index, got.last_result);
        end else begin
          want = osc_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected osc %0d index %0d last %0b, got osc %0d index %0d last %0b",
                       want.oscillator, want.sample_index, want.last_result,
                       got.oscillator, got.sample_index, got.last_result);
          end
        end
      end
      if (samples.valid && samples.ready)
        predict_beat(samples.price, samples.first_sample, samples.last_sample);
    end
    errors  <= mismatches;
    pending <= osc_expected.size();
  end

endmodule

>>> dv/tb_top.sv
// Top of the momentum oscillator testbench: clock, reset, sample and config
// stimulus, result back-pressure and the verdict. Prediction lives in umo_checker.
// Depends on umo_pkg, umo_ifs, umo_checker and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import umo_pkg::*;

  localparam int ITEM_TARGET   = 1300;
  localparam int SETTLE_CYCLES = 64;      // a warm-up beat can still be in flight
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off, fills the block
  localparam int CYCLE_LIMIT   = 1000000;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   cycles = 0;

  umo_sample_if samp_ch ();
  umo_result_if res_ch ();
  umo_cfg_if    cfg_ch ();

  unsmoothed_momentum_oscillator_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  umo_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_ch),
    .results (res_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the run hangs, e.g. a result beat never shows up
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Shared knobs between the sender and the receiver
  bit no_idle  = 1'b0;   // burst stretch: neither side idles
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  // Bookkeeping for the change ring: ring_cover is the number of leading
  // entries known to be written since reset. A window change inside a series
  // is only done when the new length stays within it, so the block never
  // drops an entry it has not written.
  int  sent_count     = 0;
  int  ring_cover     = 0;
  int  series_changes = -1;
  bit  series_clean   = 1'b1;
  int  cur_span       = 14;
  logic signed [PRICE_BITS-1:0] cur_price = '0;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CFG_W'($urandom_range(1, 6));
    if (r < 80) return CFG_W'($urandom_range(7, 20));
    if (r < 92) return CFG_W'($urandom_range(21, 63));
    if (r < 97) return CFG_W'($urandom_range(64, 127));
    return '0;
  endfunction

  // random walk with flats, jumps and the price extremes
  function automatic logic signed [PRICE_BITS-1:0] next_price(
      input logic signed [PRICE_BITS-1:0] p, input int flat_pct);
    int          r;
    logic [31:0] step;
    if ($urandom_range(0, 99) < flat_pct) return p;
    r = $urandom_range(0, 99);
    if (r < 50) return p + PRICE_BITS'(int'($urandom_range(0, 600)) - 300);
    if (r < 65) begin
      step = $urandom >> $urandom_range(1, 31);
      return $urandom_range(0, 1) ? p + step : p - step;
    end
    if (r < 85) return $urandom;
    if (r < 92) return {1'b0, {(PRICE_BITS-1){1'b1}}};
    if (r < 99) return {1'b1, {(PRICE_BITS-1){1'b0}}};
    return '0;
  endfunction

  // One sample beat. valid stays high into the next beat when no gap follows.
  task automatic send_sample(input logic signed [PRICE_BITS-1:0] p,
                             input logic f, input logic l);
    int gap;
    int covered;
    samp_ch.valid        <= 1'b1;
    samp_ch.price        <= p;
    samp_ch.first_sample <= f;
    samp_ch.last_sample  <= l;
    do @(posedge clk); while (!samp_ch.ready);
    sent_count++;
    if (f) begin
      series_changes = 0;
      series_clean   = 1'b1;
    end else begin
      series_changes++;
    end
    covered = (series_changes < cur_span) ? series_changes : cur_span;
    if (series_clean && covered > ring_cover) ring_cover = covered;
    gap = pick_gap();
    if (gap > 0) begin
      samp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_series(input int n, input bit open_new, input int flat_pct);
    for (int k = 0; k < n; k++) begin
      cur_price = next_price(cur_price, flat_pct);
      // a stray last_sample mid-series now and then
      send_sample(cur_price, open_new && k == 0,
                  (k == n - 1) || ($urandom_range(0, 99) == 0));
    end
  endtask

  // Sender pauses until every expected beat is back, then lets a
  // result-less sample finish inside the block.
  task automatic drain_results();
    samp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_span     = int'(eff_len(v));
    series_clean = 1'b0;   // a series running across the write is not counted
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    stall        = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall = 0;
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        res_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : stimulus
    int               phase;
    int               span;
    int               n_series;
    int               len_s;
    int               flat_pct;
    bit               carry_on;
    bit               open_new;
    logic [CFG_W-1:0] wv;

    rst                  = 1'b1;
    samp_ch.valid        = 1'b0;
    samp_ch.price        = '0;
    samp_ch.first_sample = 1'b0;
    samp_ch.last_sample  = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.window_length = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset window of 14, series opened by reset alone (no
    // first_sample), full-scale price swings; one result at the end.
    send_sample(32'sd0, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sd100, 1'b0, 1'b0);
    send_sample(32'sd100, 1'b0, 1'b0);
    send_sample(-32'sd5, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'sd0, 1'b0, 1'b0);
    send_sample(32'sd0, 1'b0, 1'b0);
    send_sample(-32'sd1, 1'b0, 1'b0);
    send_sample(32'sd1, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b1);

    // Directed: window of one. Pure up, pure down, flat window with the
    // flat-run clear, extreme jumps, and a sample past last_sample.
    drain_results();
    write_window(CFG_W'(1));
    send_sample(32'sd5, 1'b1, 1'b0);
    send_sample(32'sd7, 1'b0, 1'b0);
    send_sample(32'sd3, 1'b0, 1'b0);
    send_sample(32'sd3, 1'b0, 1'b0);
    send_sample(32'sd3, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    cur_price = 32'sh7FFF_FFFF;

    // Random phases: each writes the window while idle, then runs a few
    // series. Early phases pin the register extremes: 0, 127 with a series
    // long enough to fill the whole ring, then 64 inside that series.
    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      drain_results();
      case (phase)
        0:       wv = '0;
        1:       wv = CFG_W'(127);
        2:       wv = CFG_W'(64);
        default: wv = pick_window();
      endcase
      span     = int'(eff_len(wv));
      carry_on = (span <= ring_cover) && (phase == 2 || $urandom_range(0, 3) == 0);
      write_window(wv);
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase == 4 || phase == 12) begin
        // receiver holds off while the sender keeps offering beats
        no_idle  = 1'b1;
        hold_req = 1'b1;
      end
      n_series = $urandom_range(1, 3);
      for (int s = 0; s < n_series; s++) begin
        if (phase > 2 && $urandom_range(0, 9) == 0)
          len_s = $urandom_range(1, span);   // too short to leave warm-up when opened afresh
        else
          len_s = span + 1 + $urandom_range(0, (span < 8) ? 24 : span / 2);
        flat_pct = ($urandom_range(0, 4) == 0) ? 70 : 15;
        // first series after the write runs on only within the covered ring;
        // later ones sometimes run on without first_sample
        if (s == 0)
          open_new = !carry_on;
        else
          open_new = ($urandom_range(0, 15) != 0);
        run_series(len_s, open_new, flat_pct);
      end
      phase++;
    end

    drain_results();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/umo_pkg.sv
src/umo_ifs.sv
src/umo_div.sv
src/unsmoothed_momentum_oscillator_unit.sv
dv/umo_checker.sv
dv/tb_top.sv
